FILE: src/vvfm_pkg.sv
// Shared widths, constants and helpers for the voxel visible-face marker.
`timescale 1ns / 1ps

package vvfm_pkg;

    localparam int unsigned GRID_MAX_DEF = 64;
    localparam int unsigned GRID_SIZE_W  = 7;
    localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET = 7'd64;

    localparam int unsigned VOXEL_W    = 32;
    localparam int unsigned FLAGS_W    = 6;
    localparam int unsigned TOTAL_W    = 21;
    localparam int unsigned COORD_W    = 6;
    localparam int unsigned FLAG_SHIFT = 24;
    localparam int unsigned LOW_W      = FLAG_SHIFT;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_FIELD_W = VOXEL_W + FLAGS_W + TOTAL_W + 3 * COORD_W;
    localparam int unsigned M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int unsigned M_PAD_W   = M_TDATA_W - M_FIELD_W;

    // Bit positions of the face flags.
    localparam int unsigned FACE_POS_X = 0;
    localparam int unsigned FACE_NEG_X = 1;
    localparam int unsigned FACE_POS_Y = 2;
    localparam int unsigned FACE_NEG_Y = 3;
    localparam int unsigned FACE_POS_Z = 4;
    localparam int unsigned FACE_NEG_Z = 5;

    function automatic logic [2:0] face_count(input logic [FLAGS_W-1:0] flags);
        logic [2:0] cnt;
        cnt = '0;
        for (int i = 0; i < FLAGS_W; i++) begin
            cnt = cnt + {2'b00, flags[i]};
        end
        return cnt;
    endfunction

endpackage

FILE: src/vvfm_ram.sv
// Generic RAM with one write port and two registered read ports (read-first).
`timescale 1ns / 1ps

module vvfm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]                       rd_data_a,
    output logic [WIDTH-1:0]                       rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem_reg[rd_addr_a];
            rd_data_b <= mem_reg[rd_addr_b];
        end
    end

endmodule

FILE: src/voxel_visible_face_marker.sv
// Top level of the voxel visible-face marker: counters, plane stores and face evaluation.
//
//   Channel   Ports                     Contents (lowest bit first)
//   ------    ------------------------  --------------------------------------------------
//   input     s_tvalid/s_tready/s_tdata voxel_value[31:0]
//   result    m_tvalid/m_tready/m_tdata voxel_out, face_flags, face_total, out_x/y/z; m_tlast
//   config    cfg_we/cfg_wdata          grid_size[6:0]
//
// One request is taken per cycle while the result register is not stalled; it passes the
// input stage and the plane store read, then waits in the result register. Requests of
// the first plane give no result. The plane store is kept in three copies, each with two
// read ports, so the center and its five stored neighbors are read together; the +z
// neighbor is the request in hand. Reset clears counters, the running total and valids
// and loads the default grid_size; the store needs no clearing pass. A stalled result
// register stops only the stages behind it once they are full, so bubbles are squeezed out.
`timescale 1ns / 1ps

module voxel_visible_face_marker
    import vvfm_pkg::*;
#(
    parameter int unsigned GRID_MAX = GRID_MAX_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration: grid_size
    input  logic                   cfg_we,
    input  logic [GRID_SIZE_W-1:0] cfg_wdata,
    // s_tdata: voxel_value[31:0]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // m_tdata: voxel_out[31:0], face_flags[37:32], face_total[58:38], out_x[64:59],
    // out_y[70:65], out_z[76:71], zero pad[79:77]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast
);

    localparam int unsigned XW    = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int unsigned NW    = $clog2(GRID_MAX + 1);
    localparam int unsigned AW    = 2 * XW + 1;
    localparam int unsigned DEPTH = 2 ** AW;

    // Configuration and effective edge length
    logic [GRID_SIZE_W-1:0] grid_size_reg;
    logic [NW-1:0]          n;

    // Input position counters
    logic [XW-1:0] in_x_reg, in_x_next;
    logic [XW-1:0] in_y_reg, in_y_next;
    logic [NW-1:0] in_z_reg, in_z_next;
    logic          x_end, y_end, acc, acc_last;

    // Stage 1: accepted request
    logic               s1_valid_reg;
    logic [XW-1:0]      s1_x_reg, s1_y_reg;
    logic [NW-1:0]      s1_z_reg;
    logic [VOXEL_W-1:0] s1_vin_reg;
    logic               s1_last_reg;
    logic               s1_go, s1_wr, s1_par;
    logic [FLAGS_W-1:0] s1_cand;
    logic [AW-1:0]      addr_here, addr_c, addr_px, addr_mx, addr_py, addr_my;

    // Stage 2: store data and carried fields
    logic               s2_valid_reg;
    logic               s2_has_res_reg;
    logic               s2_last_reg;
    logic [XW-1:0]      s2_x_reg, s2_y_reg;
    logic [NW-1:0]      s2_zc_reg;
    logic [FLAGS_W-1:0] s2_cand_reg;
    logic [VOXEL_W-1:0] v_c, v_below, v_px, v_mx, v_py, v_my;
    logic               s2_go, s2_room;
    logic [FLAGS_W-1:0] flags, empty_nb;
    logic [TOTAL_W-1:0] total_sum;
    logic [VOXEL_W-1:0] voxel_res;

    // Result register
    logic               out_free, load_out;
    logic               m_valid_reg;
    logic [VOXEL_W-1:0] out_voxel_reg;
    logic [FLAGS_W-1:0] out_flags_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic               out_last_reg;
    logic [TOTAL_W-1:0] running_reg, running_next;

    always_comb begin
        if (grid_size_reg == '0) begin
            n = NW'(1);
        end else if (grid_size_reg > GRID_MAX) begin
            n = NW'(GRID_MAX);
        end else begin
            n = NW'(grid_size_reg);
        end
    end

    // Handshake chain; each stage moves on when the one after it has room.
    assign out_free = !m_valid_reg || m_tready;
    assign s2_go    = s2_valid_reg && (!s2_has_res_reg || out_free);
    assign s2_room  = !s2_valid_reg || s2_go;
    assign s1_go    = s1_valid_reg && s2_room;
    assign s_tready = !s1_valid_reg || s1_go;
    assign acc      = s_tvalid && s_tready;
    assign load_out = s2_go && s2_has_res_reg;

    // Raster counters
    assign x_end    = (NW'(in_x_reg) + NW'(1)) == n;
    assign y_end    = (NW'(in_y_reg) + NW'(1)) == n;
    assign acc_last = (in_z_reg >= n) && x_end && y_end;

    always_comb begin
        in_x_next = in_x_reg;
        in_y_next = in_y_reg;
        in_z_next = in_z_reg;
        if (cfg_we) begin
            in_x_next = '0;
            in_y_next = '0;
            in_z_next = '0;
        end else if (acc) begin
            if (acc_last) begin
                in_x_next = '0;
                in_y_next = '0;
                in_z_next = '0;
            end else if (x_end) begin
                in_x_next = '0;
                if (y_end) begin
                    in_y_next = '0;
                    in_z_next = in_z_reg + NW'(1);
                end else begin
                    in_y_next = in_y_reg + XW'(1);
                end
            end else begin
                in_x_next = in_x_reg + XW'(1);
            end
        end
    end

    // Stage 1 addressing. Plane z goes to parity z[0]; the center plane z-1 sits at
    // the other parity, and the same-parity entry still holds plane z-2 until written.
    assign s1_par    = s1_z_reg[0];
    assign addr_here = {s1_par, s1_y_reg, s1_x_reg};
    assign addr_c    = {~s1_par, s1_y_reg, s1_x_reg};
    assign addr_px   = {~s1_par, s1_y_reg, s1_x_reg + XW'(1)};
    assign addr_mx   = {~s1_par, s1_y_reg, s1_x_reg - XW'(1)};
    assign addr_py   = {~s1_par, s1_y_reg + XW'(1), s1_x_reg};
    assign addr_my   = {~s1_par, s1_y_reg - XW'(1), s1_x_reg};
    assign s1_wr     = s1_go && (s1_z_reg < n);

    always_comb begin
        s1_cand             = '0;
        s1_cand[FACE_POS_X] = (NW'(s1_x_reg) + NW'(1)) < n;
        s1_cand[FACE_NEG_X] = s1_x_reg != '0;
        s1_cand[FACE_POS_Y] = (NW'(s1_y_reg) + NW'(1)) < n;
        s1_cand[FACE_NEG_Y] = s1_y_reg != '0;
        // The +z neighbor is the request in hand; drain requests see the border.
        s1_cand[FACE_POS_Z] = (s1_z_reg < n) && (s1_vin_reg == '0);
        s1_cand[FACE_NEG_Z] = s1_z_reg > NW'(1);
    end

    vvfm_ram #(.WIDTH(VOXEL_W), .DEPTH(DEPTH)) u_ram_center (
        .aclk      (aclk),
        .wr_en     (s1_wr),
        .wr_addr   (addr_here),
        .wr_data   (s1_vin_reg),
        .rd_en     (s1_go),
        .rd_addr_a (addr_c),
        .rd_addr_b (addr_here),
        .rd_data_a (v_c),
        .rd_data_b (v_below)
    );

    vvfm_ram #(.WIDTH(VOXEL_W), .DEPTH(DEPTH)) u_ram_row (
        .aclk      (aclk),
        .wr_en     (s1_wr),
        .wr_addr   (addr_here),
        .wr_data   (s1_vin_reg),
        .rd_en     (s1_go),
        .rd_addr_a (addr_px),
        .rd_addr_b (addr_mx),
        .rd_data_a (v_px),
        .rd_data_b (v_mx)
    );

    vvfm_ram #(.WIDTH(VOXEL_W), .DEPTH(DEPTH)) u_ram_col (
        .aclk      (aclk),
        .wr_en     (s1_wr),
        .wr_addr   (addr_here),
        .wr_data   (s1_vin_reg),
        .rd_en     (s1_go),
        .rd_addr_a (addr_py),
        .rd_addr_b (addr_my),
        .rd_data_a (v_py),
        .rd_data_b (v_my)
    );

    // Stage 2 face evaluation
    always_comb begin
        empty_nb             = '0;
        empty_nb[FACE_POS_X] = v_px == '0;
        empty_nb[FACE_NEG_X] = v_mx == '0;
        empty_nb[FACE_POS_Y] = v_py == '0;
        empty_nb[FACE_NEG_Y] = v_my == '0;
        empty_nb[FACE_POS_Z] = 1'b1;
        empty_nb[FACE_NEG_Z] = v_below == '0;
        flags = (v_c != '0) ? (s2_cand_reg & empty_nb) : '0;
        if (flags != '0) begin
            voxel_res = {2'b00, flags, v_c[LOW_W-1:0]};
        end else begin
            voxel_res = v_c;
        end
    end

    assign total_sum = running_reg + TOTAL_W'(face_count(flags));

    always_comb begin
        running_next = running_reg;
        if (cfg_we) begin
            running_next = '0;
        end else if (load_out) begin
            running_next = s2_last_reg ? '0 : total_sum;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= GRID_SIZE_RESET;
            in_x_reg      <= '0;
            in_y_reg      <= '0;
            in_z_reg      <= '0;
            running_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                grid_size_reg <= cfg_wdata;
            end
            in_x_reg    <= in_x_next;
            in_y_reg    <= in_y_next;
            in_z_reg    <= in_z_next;
            running_reg <= running_next;
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_room) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_x_reg    <= in_x_reg;
            s1_y_reg    <= in_y_reg;
            s1_z_reg    <= in_z_reg;
            s1_vin_reg  <= s_tdata[VOXEL_W-1:0];
            s1_last_reg <= acc_last;
        end
        if (s1_go) begin
            s2_has_res_reg <= s1_z_reg != '0;
            s2_last_reg    <= s1_last_reg;
            s2_x_reg       <= s1_x_reg;
            s2_y_reg       <= s1_y_reg;
            s2_zc_reg      <= s1_z_reg - NW'(1);
            s2_cand_reg    <= s1_cand;
        end
        if (load_out) begin
            out_voxel_reg <= voxel_res;
            out_flags_reg <= flags;
            out_total_reg <= total_sum;
            out_x_reg     <= COORD_W'(s2_x_reg);
            out_y_reg     <= COORD_W'(s2_y_reg);
            out_z_reg     <= COORD_W'(s2_zc_reg);
            out_last_reg  <= s2_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_z_reg, out_y_reg, out_x_reg,
                       out_total_reg, out_flags_reg, out_voxel_reg};

    // The input position never leaves the grid plus the drain plane.
    a_pos_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (NW'(in_x_reg) < n) && (NW'(in_y_reg) < n) && (in_z_reg <= n))
        else $error("input position outside the grid");

    // Accepting the final drain request starts a new grid.
    a_grid_wrap : assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && acc_last && !cfg_we) |=>
        (in_x_reg == '0) && (in_y_reg == '0) && (in_z_reg == '0))
        else $error("counters not cleared after the last request");

    // The running total restarts once the last result is loaded.
    a_total_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && s2_last_reg) |=> (running_reg == '0))
        else $error("face total not cleared after the last result");

    // A result is only loaded when the result register is free or being emptied.
    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_tready))
        else $error("pending result overwritten");

endmodule
